@@ design/mqpub_pkg.sv @@
package mqpub_pkg;

  // event codes carried on the mode field
  localparam logic [3:0] MODE_START     = 4'd0;
  localparam logic [3:0] MODE_PUBACK    = 4'd1;
  localparam logic [3:0] MODE_PUBREC    = 4'd2;
  localparam logic [3:0] MODE_PUBCOMP   = 4'd3;
  localparam logic [3:0] MODE_TICK      = 4'd4;
  localparam logic [3:0] MODE_RECONNECT = 4'd5;
  localparam logic [3:0] MODE_FORCE_DUP = 4'd6;
  localparam logic [3:0] MODE_RESUME    = 4'd7;
  localparam logic [3:0] MODE_CANCEL    = 4'd8;

  // transmit kinds
  localparam logic [1:0] TX_NONE = 2'd0;
  localparam logic [1:0] TX_PUB  = 2'd1;
  localparam logic [1:0] TX_DUP  = 2'd2;
  localparam logic [1:0] TX_REL  = 2'd3;

  // completion status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PROTO    = 3'd1;
  localparam logic [2:0] ST_INTERNAL = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_CANCEL   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_QOS_LEVEL        = 2'd0;
  localparam logic [1:0] REG_RESEND_LIMIT     = 2'd1;
  localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_FULL_ORDERING    = 2'd3;

  // configuration reset values
  localparam logic [1:0]  QOS_RST     = 2'd0;
  localparam logic [7:0]  LIMIT_RST   = 8'd2;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;

  typedef struct packed {
    logic [1:0]  qos_level;
    logic [7:0]  resend_limit;
    logic [15:0] response_timeout;
    logic        full_ordering;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] packet_id;
    logic        tx_ok;
    logic        order_blocked;
    logic        link_up;
  } evt_t;

  typedef struct packed {
    logic [1:0]  tx_kind;
    logic [15:0] tx_packet_id;
    logic        done_res;
    logic [2:0]  status;
    logic        disconnect;
    logic        is_paused;
  } res_t;

endpackage

@@ design/mqpub_cfg.sv @@
module mqpub_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output mqpub_pkg::cfg_t   cfg
);

  mqpub_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.qos_level        <= mqpub_pkg::QOS_RST;
      cfg_r.resend_limit     <= mqpub_pkg::LIMIT_RST;
      cfg_r.response_timeout <= mqpub_pkg::TIMEOUT_RST;
      cfg_r.full_ordering    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mqpub_pkg::REG_QOS_LEVEL:        cfg_r.qos_level        <= cfg_data[1:0];
        mqpub_pkg::REG_RESEND_LIMIT:     cfg_r.resend_limit     <= cfg_data[7:0];
        mqpub_pkg::REG_RESPONSE_TIMEOUT: cfg_r.response_timeout <= cfg_data;
        mqpub_pkg::REG_FULL_ORDERING:    cfg_r.full_ordering    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/mqpub_core.sv @@
module mqpub_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  mqpub_pkg::cfg_t   cfg,
  input  mqpub_pkg::evt_t   evt,
  output mqpub_pkg::res_t   res
);

  typedef enum logic [1:0] {PH_IDLE, PH_PAUSED, PH_ACTIVE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic        acked_r, acked_nxt;
  logic [7:0]  attempts_r, attempts_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic        timer_r, timer_nxt;
  logic [15:0] held_r, held_nxt;

  always_comb begin
    logic       qos0, qos1, qos2;
    logic       can_send, match;
    logic       do_finish;
    logic [2:0] fin_status;
    logic       fin_disc;
    logic       first_req;
    logic [2:0] first_fail_status;
    logic       resend_req;
    logic [7:0] att_base;

    qos0 = (cfg.qos_level == 2'd0);
    qos1 = (cfg.qos_level == 2'd1);
    qos2 = cfg.qos_level[1];
    can_send = !(cfg.full_ordering && evt.order_blocked);
    match = (evt.packet_id == held_r);

    phase_nxt     = phase_r;
    acked_nxt     = acked_r;
    attempts_nxt  = attempts_r;
    countdown_nxt = countdown_r;
    timer_nxt     = timer_r;
    held_nxt      = held_r;

    res = '0;
    do_finish = 1'b0;
    fin_status = mqpub_pkg::ST_OK;
    fin_disc = 1'b0;
    first_req = 1'b0;
    first_fail_status = mqpub_pkg::ST_CANCEL;
    resend_req = 1'b0;
    att_base = attempts_r;

    unique case (evt.mode)
      mqpub_pkg::MODE_START: begin
        if (phase_r == PH_IDLE) begin
          acked_nxt = 1'b0;
          held_nxt = qos0 ? 16'd0 : evt.packet_id;
          if (!can_send) begin
            phase_nxt = PH_PAUSED;
          end else begin
            first_req = 1'b1;
            first_fail_status = mqpub_pkg::ST_CANCEL;
          end
        end
      end
      mqpub_pkg::MODE_PUBACK: begin
        if (phase_r == PH_ACTIVE && match) begin
          do_finish = 1'b1;
          fin_status = qos1 ? mqpub_pkg::ST_OK : mqpub_pkg::ST_PROTO;
          fin_disc = !qos1;
        end
      end
      mqpub_pkg::MODE_PUBREC: begin
        if (phase_r == PH_ACTIVE && match) begin
          if (!qos2 || acked_r) begin
            do_finish = 1'b1;
            fin_status = mqpub_pkg::ST_PROTO;
            fin_disc = 1'b1;
          end else begin
            acked_nxt = 1'b1;
            res.tx_kind = mqpub_pkg::TX_REL;
            res.tx_packet_id = held_r;
            if (!evt.tx_ok) begin
              do_finish = 1'b1;
              fin_status = mqpub_pkg::ST_INTERNAL;
            end else begin
              attempts_nxt = 8'd1;
              countdown_nxt = cfg.response_timeout;
              timer_nxt = 1'b1;
            end
          end
        end
      end
      mqpub_pkg::MODE_PUBCOMP: begin
        if (phase_r != PH_IDLE && match) begin
          do_finish = 1'b1;
          if (!qos2 || !acked_r) begin
            fin_status = mqpub_pkg::ST_PROTO;
            fin_disc = 1'b1;
          end
        end
      end
      mqpub_pkg::MODE_TICK: begin
        if (phase_r == PH_ACTIVE && timer_r && evt.link_up) begin
          if (countdown_r <= 16'd1) begin
            countdown_nxt = 16'd0;
            timer_nxt = 1'b0;
            resend_req = 1'b1;
          end else begin
            countdown_nxt = countdown_r - 16'd1;
          end
        end
      end
      mqpub_pkg::MODE_RECONNECT: begin
        if (phase_r == PH_ACTIVE) begin
          if (attempts_r != 8'd0) att_base = attempts_r - 8'd1;
          attempts_nxt = att_base;
          timer_nxt = 1'b0;
          countdown_nxt = 16'd0;
          resend_req = 1'b1;
        end
      end
      mqpub_pkg::MODE_FORCE_DUP: begin
        if (phase_r == PH_ACTIVE) resend_req = 1'b1;
      end
      mqpub_pkg::MODE_RESUME: begin
        if (phase_r == PH_PAUSED && can_send) begin
          first_req = 1'b1;
          first_fail_status = mqpub_pkg::ST_INTERNAL;
        end
      end
      mqpub_pkg::MODE_CANCEL: begin
        if (phase_r != PH_IDLE) begin
          do_finish = 1'b1;
          fin_status = mqpub_pkg::ST_CANCEL;
        end
      end
      default: ;
    endcase

    // first PUBLISH of the operation
    if (first_req) begin
      res.tx_kind = mqpub_pkg::TX_PUB;
      res.tx_packet_id = held_nxt;
      if (!evt.tx_ok) begin
        do_finish = 1'b1;
        fin_status = first_fail_status;
      end else if (qos0) begin
        do_finish = 1'b1;
        fin_status = mqpub_pkg::ST_OK;
      end else begin
        attempts_nxt = 8'd1;
        phase_nxt = PH_ACTIVE;
        countdown_nxt = cfg.response_timeout;
        timer_nxt = 1'b1;
      end
    end

    // resend: duplicate PUBLISH, or PUBREL once PUBREC was seen
    if (resend_req) begin
      if (att_base >= cfg.resend_limit) begin
        do_finish = 1'b1;
        fin_status = mqpub_pkg::ST_TIMEOUT;
      end else begin
        res.tx_kind = acked_r ? mqpub_pkg::TX_REL : mqpub_pkg::TX_DUP;
        res.tx_packet_id = held_r;
        if (!evt.tx_ok) begin
          do_finish = 1'b1;
          fin_status = mqpub_pkg::ST_INTERNAL;
        end else begin
          attempts_nxt = (att_base == 8'hFF) ? att_base : att_base + 8'd1;
          countdown_nxt = cfg.response_timeout;
          timer_nxt = 1'b1;
        end
      end
    end

    // completion drops the operation back to reset state
    if (do_finish) begin
      res.done_res = 1'b1;
      res.status = fin_status;
      res.disconnect = fin_disc;
      phase_nxt = PH_IDLE;
      acked_nxt = 1'b0;
      attempts_nxt = 8'd0;
      countdown_nxt = 16'd0;
      timer_nxt = 1'b0;
      held_nxt = 16'd0;
    end

    res.is_paused = (phase_nxt == PH_PAUSED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acked_r     <= 1'b0;
      attempts_r  <= 8'd0;
      countdown_r <= 16'd0;
      timer_r     <= 1'b0;
      held_r      <= 16'd0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      acked_r     <= acked_nxt;
      attempts_r  <= attempts_nxt;
      countdown_r <= countdown_nxt;
      timer_r     <= timer_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule

@@ design/mqtt_publish_qos_handshake_unit.sv @@
// Sender side of one MQTT 3.1.1 PUBLISH exchange at QoS 0, 1 or 2. Every event transfer
// on the in_ channel yields exactly one result transfer on the out_ channel, in order.
// An event is captured in an input register, resolved against the exchange state by
// combinational compare-and-count logic, and lands in an output register; a new event
// is taken every cycle as long as the output side keeps draining, so the sustained rate
// is one event per cycle. Configuration writes are always ready and take effect on the
// next event; write them only while no event is in flight.
module mqtt_publish_qos_handshake_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_packet_id,
  input  logic        in_tx_ok,
  input  logic        in_order_blocked,
  input  logic        in_link_up,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_tx_kind,
  output logic [15:0] out_tx_packet_id,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic        out_disconnect,
  output logic        out_is_paused
);

  mqpub_pkg::cfg_t cfg;
  mqpub_pkg::evt_t evt_r;
  mqpub_pkg::res_t res, res_r;
  logic            in_valid_r;
  logic            out_valid_r;
  logic            advance;

  // move the held event into the result register when that slot is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  mqpub_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mqpub_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .evt     (evt_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      evt_r.mode          <= in_mode;
      evt_r.packet_id     <= in_packet_id;
      evt_r.tx_ok         <= in_tx_ok;
      evt_r.order_blocked <= in_order_blocked;
      evt_r.link_up       <= in_link_up;
    end
    if (advance) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_tx_kind      = res_r.tx_kind;
  assign out_tx_packet_id = res_r.tx_packet_id;
  assign out_done_res     = res_r.done_res;
  assign out_status       = res_r.status;
  assign out_disconnect   = res_r.disconnect;
  assign out_is_paused    = res_r.is_paused;

endmodule
